[hw/rtl/afps_pkg.sv]
// Shared types and constants for the adaptive filter period supervisor.
// Register indexes, register widths, reset values and the register bundle type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afps_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EQUIL_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_THRESH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_MS       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD    = 3'd6;

  localparam int STILL_W  = 16;
  localparam int MOVING_W = 16;
  localparam int EQUIL_W  = 13;
  localparam int ARMTH_W  = 13;
  localparam int AMP_W    = 14;
  localparam int WAIT_W   = 16;
  localparam int MAXP_W   = 4;
  localparam int TIME_W   = 32;

  localparam logic [STILL_W-1:0]  RST_STILL_THRESH  = 16'd44;
  localparam logic [MOVING_W-1:0] RST_MOVING_THRESH = 16'd87;
  localparam logic [EQUIL_W-1:0]  RST_EQUIL_THRESH  = 13'd11;
  localparam logic [ARMTH_W-1:0]  RST_ARM_THRESH    = 13'd12;
  localparam logic [AMP_W-1:0]    RST_AMP_THRESH    = 14'd137;
  localparam logic [WAIT_W-1:0]   RST_WAIT_MS       = 16'd500;
  localparam logic [MAXP_W-1:0]   RST_MAX_PERIOD    = 4'd2;

  typedef struct packed {
    logic [STILL_W-1:0]  still_thresh;
    logic [MOVING_W-1:0] moving_thresh;
    logic [EQUIL_W-1:0]  equilibrium_thresh;
    logic [ARMTH_W-1:0]  arm_thresh;
    logic [AMP_W-1:0]    amp_thresh;
    logic [WAIT_W-1:0]   stability_wait_ms;
    logic [MAXP_W-1:0]   max_filter_period;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/afps_if.sv]
// Valid/ready channel interfaces for sample requests and result requests.
// Depends on afps_pkg for the timestamp width.
`timescale 1ns / 1ps
`default_nettype none

interface afps_in_if
  import afps_pkg::*;
#(
  parameter int ANGLE_BITS = 14
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] pend_angle;
  logic signed [ANGLE_BITS-1:0] arm_angle;
  logic [TIME_W-1:0]            now_ms;

  modport source (output valid, output pend_angle, output arm_angle, output now_ms,
                  input ready);
  modport sink   (input valid, input pend_angle, input arm_angle, input now_ms,
                  output ready);
endinterface

interface afps_out_if #(
  parameter int PERIOD_BITS = 4
);
  logic                   valid;
  logic                   ready;
  logic [PERIOD_BITS-1:0] filter_period;
  logic                   filter_on;
  logic                   is_stable;
  logic                   clear_integral;

  modport source (output valid, output filter_period, output filter_on,
                  output is_stable, output clear_integral, input ready);
  modport sink   (input valid, input filter_period, input filter_on,
                  input is_stable, input clear_integral, output ready);
endinterface

`default_nettype wire

[hw/rtl/afps_cfg.sv]
// Configuration register file: seven write-only thresholds and limits.
// Depends on afps_pkg for indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module afps_cfg
  import afps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.still_thresh       <= RST_STILL_THRESH;
      cfg_r.moving_thresh      <= RST_MOVING_THRESH;
      cfg_r.equilibrium_thresh <= RST_EQUIL_THRESH;
      cfg_r.arm_thresh         <= RST_ARM_THRESH;
      cfg_r.amp_thresh         <= RST_AMP_THRESH;
      cfg_r.stability_wait_ms  <= RST_WAIT_MS;
      cfg_r.max_filter_period  <= RST_MAX_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STILL_THRESH:  cfg_r.still_thresh       <= cfg_wdata[STILL_W-1:0];
        REG_MOVING_THRESH: cfg_r.moving_thresh      <= cfg_wdata[MOVING_W-1:0];
        REG_EQUIL_THRESH:  cfg_r.equilibrium_thresh <= cfg_wdata[EQUIL_W-1:0];
        REG_ARM_THRESH:    cfg_r.arm_thresh         <= cfg_wdata[ARMTH_W-1:0];
        REG_AMP_THRESH:    cfg_r.amp_thresh         <= cfg_wdata[AMP_W-1:0];
        REG_WAIT_MS:       cfg_r.stability_wait_ms  <= cfg_wdata[WAIT_W-1:0];
        REG_MAX_PERIOD:    cfg_r.max_filter_period  <= cfg_wdata[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hw/rtl/afps_core.sv]
// Supervisor step logic and its state: stability loss, disable/enable ramps and
// the four-phase oscillation detector. Depends on afps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afps_core
  import afps_pkg::*;
#(
  parameter int ANGLE_BITS  = 14,
  parameter int PERIOD_BITS = 4
)(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cfg_t                         cfg,
  input  wire logic                         step,
  input  wire logic signed [ANGLE_BITS-1:0] pend_angle,
  input  wire logic signed [ANGLE_BITS-1:0] arm_angle,
  input  wire logic [TIME_W-1:0]            now_ms,
  output logic [PERIOD_BITS-1:0]            res_period,
  output logic                              res_filter_on,
  output logic                              res_stable,
  output logic                              res_clear
);

  localparam int DW  = ANGLE_BITS + 1;
  localparam int CW  = ANGLE_BITS + 8;
  localparam int PW2 = PERIOD_BITS + MAXP_W;
  localparam logic [PW2-1:0] PMASK = PW2'((1 << PERIOD_BITS) - 1);
  localparam logic [PERIOD_BITS-1:0] PONE = PERIOD_BITS'(1);

  logic                   stable_r, stable_nxt;
  logic                   filter_r, filter_nxt;
  logic                   dis_r, dis_nxt;
  logic                   en_r, en_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [ANGLE_BITS-1:0]  first_r, first_nxt;
  logic [ANGLE_BITS-1:0]  second_r, second_nxt;
  logic [ANGLE_BITS-1:0]  prev_r, prev_nxt;
  logic [TIME_W-1:0]      last_r, last_nxt;
  logic                   clear_nxt;

  logic signed [DW-1:0] arm_d, amp_d;
  logic [DW-1:0]        arm_dmag, amp_mag;
  logic [ANGLE_BITS-1:0] pend_mag, arm_mag;
  logic [CW-1:0]        speed, amp_w, pend_w, arm_w;
  logic [CW-1:0]        still_w, moving_w, equil_w, armth_w, ampth_w;
  logic [TIME_W-1:0]    elapsed;
  logic                 holdoff_done, is_still, is_moving, settled;
  logic [PW2-1:0]       max_eff;

  assign arm_d    = DW'(arm_angle) - DW'($signed(prev_r));
  assign arm_dmag = arm_d[DW-1] ? DW'(-arm_d) : DW'(arm_d);
  assign amp_d    = DW'($signed(second_r)) - DW'($signed(first_r));
  assign amp_mag  = amp_d[DW-1] ? DW'(-amp_d) : DW'(amp_d);
  assign pend_mag = pend_angle[ANGLE_BITS-1] ? ANGLE_BITS'(-pend_angle)
                                             : ANGLE_BITS'(pend_angle);
  assign arm_mag  = arm_angle[ANGLE_BITS-1] ? ANGLE_BITS'(-arm_angle)
                                            : ANGLE_BITS'(arm_angle);

  assign speed    = CW'({arm_dmag, 6'b0});
  assign amp_w    = CW'(amp_mag);
  assign pend_w   = CW'(pend_mag);
  assign arm_w    = CW'(arm_mag);
  assign still_w  = CW'(cfg.still_thresh);
  assign moving_w = CW'(cfg.moving_thresh);
  assign equil_w  = CW'(cfg.equilibrium_thresh);
  assign armth_w  = CW'(cfg.arm_thresh);
  assign ampth_w  = CW'(cfg.amp_thresh);

  assign elapsed      = now_ms - last_r;
  assign holdoff_done = elapsed > TIME_W'(cfg.stability_wait_ms);
  assign is_still     = speed < still_w;
  assign is_moving    = speed > moving_w;
  assign max_eff      = PW2'(cfg.max_filter_period) & PMASK;

  always_comb begin
    stable_nxt = stable_r;
    filter_nxt = filter_r;
    dis_nxt    = dis_r;
    en_nxt     = en_r;
    period_nxt = period_r;
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    prev_nxt   = prev_r;
    last_nxt   = last_r;
    clear_nxt  = 1'b0;
    settled    = 1'b0;
    if (holdoff_done) begin
      if (pend_w > equil_w && stable_r) begin
        dis_nxt    = 1'b1;
        stable_nxt = 1'b0;
      end
      if (dis_nxt) begin
        if (period_nxt <= PONE) begin
          dis_nxt    = 1'b0;
          filter_nxt = 1'b0;
        end else begin
          period_nxt = period_nxt - PONE;
        end
      end
      if (!filter_nxt) begin
        if (!en_r) begin
          // oscillation detector: still, moving, still, then amplitude
          prev_nxt = arm_angle;
          if (is_still && phase_r == 2'd0) begin
            first_nxt = arm_angle;
            phase_nxt = 2'd1;
          end else if (is_moving && phase_r == 2'd1) begin
            phase_nxt = 2'd2;
          end else if (is_still && phase_r == 2'd2) begin
            second_nxt = arm_angle;
            phase_nxt  = 2'd3;
          end else if (phase_r == 2'd3) begin
            phase_nxt = 2'd0;
            settled   = amp_w < ampth_w;
          end
          if (settled) begin
            en_nxt = 1'b1;
          end
        end
        if (en_nxt && arm_w < armth_w) begin
          if (PW2'(period_nxt) >= max_eff) begin
            en_nxt     = 1'b0;
            stable_nxt = 1'b1;
            filter_nxt = 1'b1;
            clear_nxt  = 1'b1;
            last_nxt   = now_ms;
          end else begin
            period_nxt = period_nxt + PONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      filter_r <= 1'b0;
      dis_r    <= 1'b0;
      en_r     <= 1'b0;
      period_r <= PONE;
      phase_r  <= 2'd0;
      first_r  <= '0;
      second_r <= '0;
      prev_r   <= '0;
      last_r   <= '0;
    end else if (step) begin
      stable_r <= stable_nxt;
      filter_r <= filter_nxt;
      dis_r    <= dis_nxt;
      en_r     <= en_nxt;
      period_r <= period_nxt;
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      prev_r   <= prev_nxt;
      last_r   <= last_nxt;
    end
  end

  assign res_period    = period_nxt;
  assign res_filter_on = filter_nxt;
  assign res_stable    = stable_nxt;
  assign res_clear     = clear_nxt;

  a_stable_implies_on: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |-> (filter_r && !en_r))
    else $error("stable without filter on, or with enable ramp armed");

  a_disable_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
    dis_r |-> filter_r)
    else $error("disable ramp running with filter off");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    period_r != '0)
    else $error("filter period reached zero");

  a_clear_on_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_clear) |=> (filter_r && stable_r && last_r == $past(now_ms)))
    else $error("integral clear without completed enable");

endmodule

`default_nettype wire

[hw/rtl/adaptive_filter_period_supervisor_top.sv]
// Top level of the adaptive filter period supervisor.
// Instantiates afps_cfg and afps_core; uses afps_pkg and the afps_if channels.
//
// Usage:
//   in_ch  : sample requests (pend_angle, arm_angle, now_ms), valid/ready.
//   out_ch : one result request per sample (filter_period, filter_on,
//            is_stable, clear_integral), valid/ready.
//   cfg_*  : write-only port; user writes only while block idle, unenforced.
// Timing: an accepted sample is held in the input register; the step logic
//   then updates the supervisor state and loads the output register.
//   Throughput is one sample per cycle while out_ch.ready stays high.
// Stall: while a result waits in the output register, one more sample can be
//   taken into the input register; in_ch.ready then drops until out_ch.ready.
// Reset: synchronous, active low; clears the pipeline valids, the supervisor
//   state (period 1, filter off, not stable) and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_filter_period_supervisor_top
  import afps_pkg::*;
#(
  parameter int ANGLE_BITS  = 14,
  parameter int PERIOD_BITS = 4
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  afps_in_if.sink                    in_ch,
  afps_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  logic                         s1_valid_r;
  logic signed [ANGLE_BITS-1:0] s1_pend_r;
  logic signed [ANGLE_BITS-1:0] s1_arm_r;
  logic [TIME_W-1:0]            s1_now_r;

  logic                   out_valid_r;
  logic [PERIOD_BITS-1:0] out_period_r;
  logic                   out_on_r;
  logic                   out_stable_r;
  logic                   out_clear_r;

  logic                   step;
  logic                   in_take;
  logic [PERIOD_BITS-1:0] res_period;
  logic                   res_filter_on;
  logic                   res_stable;
  logic                   res_clear;

  assign step         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || step;
  assign in_take      = in_ch.valid && in_ch.ready;

  afps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afps_core #(
    .ANGLE_BITS  (ANGLE_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .step          (step),
    .pend_angle    (s1_pend_r),
    .arm_angle     (s1_arm_r),
    .now_ms        (s1_now_r),
    .res_period    (res_period),
    .res_filter_on (res_filter_on),
    .res_stable    (res_stable),
    .res_clear     (res_clear)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pend_r <= in_ch.pend_angle;
      s1_arm_r  <= in_ch.arm_angle;
      s1_now_r  <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_period_r <= res_period;
      out_on_r     <= res_filter_on;
      out_stable_r <= res_stable;
      out_clear_r  <= res_clear;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filter_period  = out_period_r;
  assign out_ch.filter_on      = out_on_r;
  assign out_ch.is_stable      = out_stable_r;
  assign out_ch.clear_integral = out_clear_r;

endmodule

`default_nettype wire
